// ----- rtl/polygon_perimeter_macros.svh -----
// ----------------------------------------------------------------------------
// polygon_perimeter_macros.svh
// Assertion shorthands for the polygon perimeter block. Each macro expects
// clk and arst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef POLYGON_PERIMETER_MACROS_SVH
`define POLYGON_PERIMETER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PGP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("polygon_perimeter: check failed");

// Next-cycle implication, disabled while reset is asserted
`define PGP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("polygon_perimeter: check failed");

`endif

// ----- rtl/pgp_pkg.sv -----
// ----------------------------------------------------------------------------
// pgp_pkg
// Shared widths, defaults and types of the polygon perimeter block.
// ----------------------------------------------------------------------------
package pgp_pkg;

	// Coordinate and arithmetic widths
	localparam int COORD_W    = 24;
	localparam int MAG_W      = COORD_W;
	localparam int SQ_W       = 2 * MAG_W + 1;
	localparam int ROOT_W     = (SQ_W + 1) / 2;
	localparam int SUM_W      = 32;
	localparam int CNT_W      = 8;
	localparam int SQ_CNT_W   = $clog2(MAG_W);
	localparam int ROOT_CNT_W = $clog2(ROOT_W);

	// Stream word widths
	localparam int IN_TDATA_W  = 2 * COORD_W;
	localparam int OUT_TDATA_W = SUM_W + CNT_W;

	// Default vertex count limit
	localparam int MAX_POINTS_DEF = 128;

	// End points of one edge
	typedef struct packed {
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
	} pgp_seg_t;

endpackage

// ----- rtl/pgp_sqmag.sv -----
// ----------------------------------------------------------------------------
// pgp_sqmag
// Squared edge length dx*dx + dy*dy, two bit-serial shift-add squarers
// working side by side, one multiplier bit per cycle, then one final add.
// ----------------------------------------------------------------------------
module pgp_sqmag (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  pgp_pkg::pgp_seg_t        seg,
	output logic                     done,
	output logic [pgp_pkg::SQ_W-1:0] sum_sq
);
	import pgp_pkg::*;

	logic signed [COORD_W:0] dx_w, dy_w;
	logic        [COORD_W:0] ndx_w, ndy_w;
	logic [MAG_W-1:0]        mag_x_w, mag_y_w;
	logic [MAG_W:0]          tx_w, ty_w;

	logic [MAG_W-1:0]    mcx_q, mcy_q, mpx_q, mpy_q;
	logic [MAG_W-1:0]    hix_q, hiy_q, lox_q, loy_q;
	logic [SQ_CNT_W-1:0] cnt_q;
	logic                busy_q, add_q, done_q;
	logic [SQ_W-1:0]     sum_q;

	// Absolute differences of the end points
	assign dx_w    = {seg.ax[COORD_W-1], seg.ax} - {seg.bx[COORD_W-1], seg.bx};
	assign dy_w    = {seg.ay[COORD_W-1], seg.ay} - {seg.by[COORD_W-1], seg.by};
	assign ndx_w   = -dx_w;
	assign ndy_w   = -dy_w;
	assign mag_x_w = dx_w[COORD_W] ? ndx_w[MAG_W-1:0] : dx_w[MAG_W-1:0];
	assign mag_y_w = dy_w[COORD_W] ? ndy_w[MAG_W-1:0] : dy_w[MAG_W-1:0];

	// Partial product step: add the multiplicand when the current bit is set
	assign tx_w = {1'b0, hix_q} + (mpx_q[0] ? {1'b0, mcx_q} : '0);
	assign ty_w = {1'b0, hiy_q} + (mpy_q[0] ? {1'b0, mcy_q} : '0);

	// Sequence the bit steps and the final add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			add_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SQ_CNT_W'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					add_q  <= 1'b1;
				end
			end else if (add_q) begin
				add_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Shift the products right, low bits into the low halves
	always_ff @(posedge clk) begin
		if (start) begin
			mcx_q <= mag_x_w;
			mcy_q <= mag_y_w;
			mpx_q <= mag_x_w;
			mpy_q <= mag_y_w;
			hix_q <= '0;
			hiy_q <= '0;
			lox_q <= '0;
			loy_q <= '0;
		end else if (busy_q) begin
			hix_q <= tx_w[MAG_W:1];
			hiy_q <= ty_w[MAG_W:1];
			lox_q <= {tx_w[0], lox_q[MAG_W-1:1]};
			loy_q <= {ty_w[0], loy_q[MAG_W-1:1]};
			mpx_q <= mpx_q >> 1;
			mpy_q <= mpy_q >> 1;
		end else if (add_q) begin
			sum_q <= {1'b0, hix_q, lox_q} + {1'b0, hiy_q, loy_q};
		end
	end

	assign done   = done_q;
	assign sum_sq = sum_q;

endmodule

// ----- rtl/pgp_isqrt.sv -----
// ----------------------------------------------------------------------------
// pgp_isqrt
// Floor integer square root, restoring digit-by-digit method: two radicand
// bits enter and one root bit leaves each cycle.
// ----------------------------------------------------------------------------
module pgp_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pgp_pkg::SQ_W-1:0]   rad,
	output logic                       done,
	output logic [pgp_pkg::ROOT_W-1:0] root
);
	import pgp_pkg::*;

	localparam int RAD_W = 2 * ROOT_W;

	logic [RAD_W-1:0]      rad_q;
	logic [ROOT_W:0]       rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [ROOT_CNT_W-1:0] cnt_q;
	logic                  busy_q, done_q;

	logic [ROOT_W+2:0] r_w, trial_w, diff_w;
	logic              ge_w;

	// Trial subtraction of (root << 2) | 1 from the shifted remainder
	assign r_w     = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial_w = {1'b0, root_q, 2'b01};
	assign diff_w  = r_w - trial_w;
	assign ge_w    = (r_w >= trial_w);

	// Count the root bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ROOT_CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Advance the remainder, the root and the radicand
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RAD_W'(rad);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge_w ? diff_w[ROOT_W:0] : r_w[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], ge_w};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- rtl/polygon_perimeter.sv -----
// ----------------------------------------------------------------------------
// polygon_perimeter
// Streams polygon vertices in and returns the perimeter and vertex count.
// ----------------------------------------------------------------------------
// Input words carry one vertex each (x, y signed, 8 fraction bits); tlast
// marks the final vertex of a polygon. One output word per polygon carries
// the saturated perimeter (8 fraction bits) and the saturated vertex count.
// The first vertex of a polygon, unless it is also the last, is only stored
// and the block stays ready for the next. Every further vertex adds one edge:
// the block loads it, squares it in the serial squarer, hands the squared
// length to the serial square root, accumulates the root and returns to idle;
// it takes no new vertex until that edge is done. The last vertex also adds
// the closing edge, so its result is registered only after both edges are
// done; a single-vertex polygon takes one edge of zero length. The squarer
// and the root unit each work one bit per cycle; one vertex is worked on at a
// time and tready is high only while the block waits for a vertex. The result
// sits in an output register: the block accepts new vertices while it waits,
// and holds a later result back until the register is free.
// Reset clears the running sum, the vertex count and the output valid, so
// the next vertex starts a new polygon.
// ----------------------------------------------------------------------------
`include "polygon_perimeter_macros.svh"

module polygon_perimeter #(
	parameter int MAX_POINTS = pgp_pkg::MAX_POINTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [pgp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // x, y
	input  logic                            s_axis_tlast,   // last
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [pgp_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // perimeter, point_count
);
	import pgp_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_SQ   = 5'b00100,
		ST_ROOT = 5'b01000,
		ST_ACC  = 5'b10000
	} state_t;

	state_t state_q;

	logic signed [COORD_W-1:0] in_x_w, in_y_w;
	logic signed [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	pgp_seg_t                  seg_q;
	logic                      last_q, closing_q;
	logic [SUM_W-1:0]          sum_q;
	logic [CNT_W-1:0]          count_q;
	logic                      out_valid_q;
	logic [SUM_W-1:0]          out_sum_q;
	logic [CNT_W-1:0]          out_cnt_q;

	logic                      in_fire_w, out_free_w, out_load_w;
	logic                      sq_start_w, sq_done_w;
	logic [SQ_W-1:0]           sq_sum_w;
	logic                      rt_done_w;
	logic [ROOT_W-1:0]         rt_root_w;
	logic [SUM_W:0]            sum_ext_w;

	assign in_x_w     = s_axis_tdata[COORD_W-1:0];
	assign in_y_w     = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign in_fire_w  = s_axis_tvalid && (state_q == ST_IDLE);
	assign out_free_w = !out_valid_q || m_axis_tready;
	assign out_load_w = (state_q == ST_ACC) && last_q && closing_q && out_free_w;
	assign sq_start_w = (state_q == ST_LOAD);
	assign sum_ext_w  = {1'b0, sum_q} + (SUM_W + 1)'(rt_root_w);

	// Squared length of the current edge
	pgp_sqmag u_sqmag (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start_w),
		.seg    (seg_q),
		.done   (sq_done_w),
		.sum_sq (sq_sum_w)
	);

	// Edge length from the squared length
	pgp_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_done_w),
		.rad    (sq_sum_w),
		.done   (rt_done_w),
		.root   (rt_root_w)
	);

	// Sequence vertices, edges and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			count_q     <= '0;
			last_q      <= 1'b0;
			closing_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load_w) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire_w) begin
						last_q <= s_axis_tlast;
						if (count_q == '0) begin
							sum_q     <= '0;
							count_q   <= CNT_W'(1);
							closing_q <= 1'b1;
							if (s_axis_tlast) begin
								state_q <= ST_LOAD;
							end
						end else begin
							closing_q <= 1'b0;
							state_q   <= ST_LOAD;
							if (count_q < CNT_W'(MAX_POINTS)) begin
								count_q <= count_q + 1'b1;
							end
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					if (sq_done_w) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (rt_done_w) begin
						sum_q   <= sum_ext_w[SUM_W] ? '1 : sum_ext_w[SUM_W-1:0];
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (!closing_q) begin
						closing_q <= 1'b1;
						state_q   <= ST_LOAD;
					end else if (out_free_w) begin
						sum_q       <= '0;
						count_q     <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold vertices, edge end points and the result word
	always_ff @(posedge clk) begin
		if (in_fire_w) begin
			prev_x_q <= in_x_w;
			prev_y_q <= in_y_w;
			if (count_q == '0) begin
				first_x_q <= in_x_w;
				first_y_q <= in_y_w;
				seg_q     <= '{ax: in_x_w, ay: in_y_w, bx: in_x_w, by: in_y_w};
			end else begin
				seg_q <= '{ax: prev_x_q, ay: prev_y_q, bx: in_x_w, by: in_y_w};
			end
		end else if (state_q == ST_ACC && last_q && !closing_q) begin
			seg_q <= '{ax: prev_x_q, ay: prev_y_q, bx: first_x_q, by: first_y_q};
		end
		if (out_load_w) begin
			out_sum_q <= sum_q;
			out_cnt_q <= count_q;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_cnt_q, out_sum_q};

	`PGP_ASSERT_IMPL(a_cnt_range, 1'b1, count_q <= CNT_W'(MAX_POINTS))
	`PGP_ASSERT_IMPL(a_out_cnt, out_valid_q, out_cnt_q != '0)
	`PGP_ASSERT_IMPL(a_sq_state, sq_done_w, state_q == ST_SQ)
	`PGP_ASSERT_IMPL(a_root_state, rt_done_w, state_q == ST_ROOT)
	`PGP_ASSERT_NEXT(a_edge_busy, in_fire_w && count_q != '0, !s_axis_tready)

endmodule
